[rtl/core/kcrd_pkg.sv]
package kcrd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RecW   = 24;
  localparam int unsigned CntW   = 5;
  localparam int unsigned PosW   = 4;
  localparam int unsigned ValW   = 9;
  localparam int unsigned EntW   = 5;
  localparam int unsigned SumW   = 8;
  localparam int unsigned OutDataW = 48;

  localparam logic [RecW-1:0] RecMax = {RecW{1'b1}};

  localparam logic [0:0] CfgFirstRecord = 1'b0;
  localparam logic [0:0] CfgLastRecord  = 1'b1;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // b / 17 for any byte: multiply by 241 / 4096
  function automatic logic [3:0] div17(input logic [ByteW-1:0] b);
    logic [15:0] prod;
    prod = 16'(b) * 16'd241;
    return prod[15:12];
  endfunction

  // n * (n + 1) / 2
  function automatic logic [SumW-1:0] tri_num(input logic [CntW-1:0] n);
    logic [10:0] prod;
    prod = 11'(n) * (11'(n) + 11'd1);
    return prod[8:1];
  endfunction

endpackage

[rtl/core/kcrd_entry_mem.sv]
module kcrd_entry_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kcrd_pkg::mem_ctl_t     ctl_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [kcrd_pkg::EntW-1:0] wentry_i,
  input  logic [kcrd_pkg::SumW-1:0] wpsum_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [kcrd_pkg::EntW-1:0] rentry_o,
  output logic [kcrd_pkg::SumW-1:0] rpsum_o
);
  import kcrd_pkg::*;

  localparam int unsigned WordW = EntW + SumW;

  logic [WordW-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [WordW-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= {wpsum_i, wentry_i};
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.re) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // unwritten entries read as zero
  assign rentry_o = rvalid_q ? rdata_q[EntW-1:0] : '0;
  assign rpsum_o  = rvalid_q ? rdata_q[WordW-1:EntW] : '0;

endmodule

[rtl/core/knot_code_record_decoder_top.sv]
// channel   | dir | signals                               | item
// s_axis    | in  | tvalid, tready, tdata[7:0]            | one stream byte
// m_axis    | out | tvalid, tready, tdata[47:0], tlast    | one decoded entry
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i[23:0] | register write
// A header that keeps entries goes through ST_SUM (prefix-sum read from the entry
// memory); a pair byte with two new entries goes through ST_PAIR2 (one memory write
// port). Emission streams one entry per cycle from the memory read port, nc entries
// per emitted record, stalled by m_axis_tready.
// Reset: no clearing pass; per-entry valid bits make unwritten entries read zero.
module knot_code_record_decoder_top #(
  parameter int unsigned MAX_CROSSINGS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // record_number[23:0], crossing_count[28:24],
                                      // position[32:29], entry_value[41:33], zero
  output logic        m_axis_tlast,   // last_of_record
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  import kcrd_pkg::*;

  localparam int unsigned AddrW = (MAX_CROSSINGS > 1) ? $clog2(MAX_CROSSINGS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CROSSINGS);

  typedef enum logic [1:0] {
    ST_IN,
    ST_SUM,
    ST_PAIR2,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAIRS,
    PH_SIGN_A,
    PH_SIGN_B
  } phase_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic              count_known_q, count_known_d;
  logic [CntW-1:0]   crossings_q, crossings_d;
  logic [CntW-1:0]   entry_index_q, entry_index_d;
  logic [SumW-1:0]   entry_sum_q, entry_sum_d;
  logic [ByteW-1:0]  sign_a_q, sign_a_d;
  logic [15:0]       signs_q, signs_d;
  logic [RecW-1:0]   rec_cnt_q, rec_cnt_d;
  logic              stopped_q, stopped_d;
  logic [EntW-1:0]   lo_val_q, lo_val_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [RecW-1:0]   first_rec_q, last_rec_q;

  logic              m_valid_q, m_valid_d;
  logic [RecW-1:0]   out_rec_q, out_rec_d;
  logic [CntW-1:0]   out_cnt_q, out_cnt_d;
  logic [PosW-1:0]   out_pos_q, out_pos_d;
  logic [ValW-1:0]   out_val_q, out_val_d;
  logic              out_last_q, out_last_d;

  mem_ctl_t          mem_ctl;
  logic [CntW-1:0]   waddr, raddr;
  logic [EntW-1:0]   wentry, rentry;
  logic [SumW-1:0]   wpsum, rpsum;

  logic              accept;
  logic [3:0]        drop;
  logic [CntW-1:0]   nc_new, nc, lastpos, keep, hi_val, lo_val;
  logic [CntW:0]     idx_p1, idx_p2;
  logic [RecW-1:0]   rec_inc;
  logic [SumW-1:0]   sum_v, e8;
  logic [ValW-1:0]   v9;
  logic              is_last;

  kcrd_entry_mem #(
    .Depth (MAX_CROSSINGS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .waddr_i  (waddr[AddrW-1:0]),
    .wentry_i (wentry),
    .wpsum_i  (wpsum),
    .raddr_i  (raddr[AddrW-1:0]),
    .rentry_o (rentry),
    .rpsum_o  (rpsum)
  );

  assign s_axis_tready = (state_q == ST_IN);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign drop    = div17(s_axis_tdata);
  assign nc_new  = ((CntW'(drop) + 5'd1) > MaxCnt) ? MaxCnt : CntW'(drop) + 5'd1;
  assign nc      = count_known_q ? crossings_q : nc_new;
  assign lastpos = nc - 5'd1;
  assign keep    = (lastpos > CntW'(drop)) ? lastpos - CntW'(drop) : '0;
  assign idx_p1  = {1'b0, entry_index_q} + 6'd1;
  assign idx_p2  = {1'b0, entry_index_q} + 6'd2;
  assign hi_val  = {1'b0, s_axis_tdata[7:4]} + 5'd1;
  assign lo_val  = {1'b0, s_axis_tdata[3:0]} + 5'd1;
  assign rec_inc = rec_cnt_q + 24'd1;

  assign is_last = ({1'b0, pos_q} == crossings_q - 5'd1);
  assign e8      = is_last ? tri_num(crossings_q) - entry_sum_q : SumW'(rentry);
  assign v9      = {e8, 1'b0};

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    count_known_d = count_known_q;
    crossings_d   = crossings_q;
    entry_index_d = entry_index_q;
    entry_sum_d   = entry_sum_q;
    sign_a_d      = sign_a_q;
    signs_d       = signs_q;
    rec_cnt_d     = rec_cnt_q;
    stopped_d     = stopped_q;
    lo_val_d      = lo_val_q;
    pos_d         = pos_q;
    m_valid_d     = m_valid_q;
    out_rec_d     = out_rec_q;
    out_cnt_d     = out_cnt_q;
    out_pos_d     = out_pos_q;
    out_val_d     = out_val_q;
    out_last_d    = out_last_q;
    mem_ctl       = '0;
    waddr         = '0;
    raddr         = '0;
    wentry        = '0;
    wpsum         = '0;
    sum_v         = entry_sum_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IN: begin
        if (accept && !stopped_q) begin
          case (phase_q)
            PH_HEADER: begin
              if (!count_known_q) begin
                count_known_d = 1'b1;
                crossings_d   = nc_new;
              end
              if (rec_cnt_q == RecMax) begin
                stopped_d = 1'b1;
              end else begin
                rec_cnt_d = rec_inc;
                if (rec_inc > last_rec_q) begin
                  stopped_d = 1'b1;
                end else begin
                  entry_index_d = keep;
                  phase_d       = (keep < lastpos) ? PH_PAIRS : PH_SIGN_A;
                  entry_sum_d   = '0;
                  if (keep != '0) begin
                    mem_ctl.re = 1'b1;
                    raddr      = keep - 5'd1;
                    state_d    = ST_SUM;
                  end
                end
              end
            end
            PH_PAIRS: begin
              if (entry_index_q < lastpos) begin
                sum_v      = entry_sum_q + SumW'(hi_val);
                mem_ctl.we = 1'b1;
                waddr      = entry_index_q;
                wentry     = hi_val;
                wpsum      = sum_v;
              end
              entry_sum_d = sum_v;
              if (idx_p1 < {1'b0, lastpos}) begin
                lo_val_d = lo_val;
                state_d  = ST_PAIR2;
              end
              entry_index_d = idx_p2[CntW-1:0];
              if (idx_p2 >= {1'b0, lastpos}) begin
                phase_d = PH_SIGN_A;
              end
            end
            PH_SIGN_A: begin
              sign_a_d = s_axis_tdata;
              phase_d  = PH_SIGN_B;
            end
            PH_SIGN_B: begin
              phase_d = PH_HEADER;
              if (rec_cnt_q >= first_rec_q) begin
                signs_d    = {sign_a_q, s_axis_tdata};
                pos_d      = '0;
                mem_ctl.re = 1'b1;
                raddr      = '0;
                state_d    = ST_EMIT;
              end
            end
            default: begin
              phase_d = PH_HEADER;
            end
          endcase
        end
      end
      ST_SUM: begin
        entry_sum_d = rpsum;
        state_d     = ST_IN;
      end
      ST_PAIR2: begin
        sum_v       = entry_sum_q + SumW'(lo_val_q);
        mem_ctl.we  = 1'b1;
        waddr       = entry_index_q - 5'd1;
        wentry      = lo_val_q;
        wpsum       = sum_v;
        entry_sum_d = sum_v;
        state_d     = ST_IN;
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          out_rec_d  = rec_cnt_q;
          out_cnt_d  = crossings_q;
          out_pos_d  = pos_q;
          out_val_d  = signs_q[15] ? v9 : 9'd0 - v9;
          out_last_d = is_last;
          signs_d    = {signs_q[14:0], 1'b0};
          if (is_last) begin
            state_d = ST_IN;
          end else begin
            pos_d      = pos_q + 4'd1;
            mem_ctl.re = 1'b1;
            raddr      = {1'b0, pos_q} + 5'd1;
          end
        end
      end
      default: begin
        state_d = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IN;
      phase_q       <= PH_HEADER;
      count_known_q <= 1'b0;
      crossings_q   <= '0;
      entry_index_q <= '0;
      entry_sum_q   <= '0;
      sign_a_q      <= '0;
      signs_q       <= '0;
      rec_cnt_q     <= '0;
      stopped_q     <= 1'b0;
      lo_val_q      <= '0;
      pos_q         <= '0;
      first_rec_q   <= 24'd1;
      last_rec_q    <= RecMax;
      m_valid_q     <= 1'b0;
      out_rec_q     <= '0;
      out_cnt_q     <= '0;
      out_pos_q     <= '0;
      out_val_q     <= '0;
      out_last_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      count_known_q <= count_known_d;
      crossings_q   <= crossings_d;
      entry_index_q <= entry_index_d;
      entry_sum_q   <= entry_sum_d;
      sign_a_q      <= sign_a_d;
      signs_q       <= signs_d;
      rec_cnt_q     <= rec_cnt_d;
      stopped_q     <= stopped_d;
      lo_val_q      <= lo_val_d;
      pos_q         <= pos_d;
      m_valid_q     <= m_valid_d;
      out_rec_q     <= out_rec_d;
      out_cnt_q     <= out_cnt_d;
      out_pos_q     <= out_pos_d;
      out_val_q     <= out_val_d;
      out_last_q    <= out_last_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFirstRecord: first_rec_q <= cfg_data_i;
          CfgLastRecord:  last_rec_q  <= cfg_data_i;
          default:        first_rec_q <= first_rec_q;
        endcase
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, out_val_q, out_pos_q, out_cnt_q, out_rec_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  import kcrd_pkg::*;

  localparam int unsigned MaxCrossings = 16;
  localparam int unsigned DrainCycles  = 32;
  localparam int unsigned HoldCycles   = 400;

  typedef enum logic [1:0] {
    AwaitHeader,
    AwaitPairs,
    AwaitSignHi,
    AwaitSignLo
  } stream_phase_e;

  typedef struct packed {
    logic [RecW-1:0] rec;
    logic [CntW-1:0] cnt;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    logic            last;
  } knot_entry_t;

  class kcrd_entry_book;
    logic [RecW-1:0] first_rec;
    logic [RecW-1:0] last_rec;
    bit              count_known;
    logic [CntW-1:0] nc;
    stream_phase_e   ph;
    logic [4:0]      idx;
    logic [EntW-1:0] ent [16];
    logic [SumW-1:0] sum;
    logic [7:0]      sign_hi;
    logic [RecW-1:0] rec_cnt;
    bit              halted;
    knot_entry_t     pending_entries [$];
    int unsigned     errors;
    int unsigned     n_bytes;
    int unsigned     n_entries;

    function new();
      first_rec   = 24'd1;
      last_rec    = RecMax;
      count_known = 1'b0;
      nc          = '0;
      ph          = AwaitHeader;
      idx         = '0;
      foreach (ent[i]) ent[i] = '0;
      sum         = '0;
      sign_hi     = '0;
      rec_cnt     = '0;
      halted      = 1'b0;
      errors      = 0;
      n_bytes     = 0;
      n_entries   = 0;
    endfunction

    function void write_reg(logic [0:0] index, logic [RecW-1:0] value);
      if (index == CfgFirstRecord) first_rec = value;
      else last_rec = value;
    endfunction

    function void absorb_byte(logic [7:0] b);
      int unsigned n, lastpos, drop, keep, i, tri_v;
      int          e, v;
      logic [15:0] signs;
      knot_entry_t x;
      if (halted) return;
      n_bytes++;
      lastpos = (nc == 0) ? 0 : int'(nc) - 1;
      case (ph)
        AwaitHeader: begin
          if (!count_known) begin
            n = b / 17 + 1;
            if (n > MaxCrossings) n = MaxCrossings;
            nc = CntW'(n);
            count_known = 1'b1;
            lastpos = n - 1;
          end
          if (rec_cnt == RecMax) begin
            halted = 1'b1;
            return;
          end
          rec_cnt = rec_cnt + 1'b1;
          if (rec_cnt > last_rec) begin
            halted = 1'b1;
            return;
          end
          drop = b / 17;
          keep = (lastpos > drop) ? lastpos - drop : 0;
          sum = '0;
          for (i = 0; i < keep; i++) sum = sum + SumW'(ent[i & 15]);
          idx = 5'(keep);
          ph = (keep < lastpos) ? AwaitPairs : AwaitSignHi;
        end
        AwaitPairs: begin
          i = idx;
          if (i < lastpos) begin
            ent[i & 15] = EntW'(b[7:4]) + 1'b1;
            sum = sum + SumW'(b[7:4]) + 1'b1;
          end
          if (i + 1 < lastpos) begin
            ent[(i + 1) & 15] = EntW'(b[3:0]) + 1'b1;
            sum = sum + SumW'(b[3:0]) + 1'b1;
          end
          idx = 5'(i + 2);
          if (i + 2 >= lastpos) ph = AwaitSignHi;
        end
        AwaitSignHi: begin
          sign_hi = b;
          ph = AwaitSignLo;
        end
        default: begin
          ph = AwaitHeader;
          if (rec_cnt < first_rec) return;
          signs = {sign_hi, b};
          tri_v = (nc * (nc + 1)) / 2;
          for (i = 0; i < nc; i++) begin
            if (i == lastpos) e = int'(tri_v) - int'(sum);
            else e = int'(ent[i & 15]);
            v = 2 * e;
            if (!signs[15 - i]) v = -v;
            x.rec  = rec_cnt;
            x.cnt  = nc;
            x.pos  = PosW'(i);
            x.val  = v[ValW-1:0];
            x.last = (i == lastpos);
            pending_entries.push_back(x);
          end
        end
      endcase
    endfunction

    function void match_entry(logic [OutDataW-1:0] d, logic l);
      knot_entry_t x;
      if (pending_entries.size() == 0) begin
        $error("unexpected entry: tdata %h tlast %b", d, l);
        errors++;
        return;
      end
      x = pending_entries.pop_front();
      n_entries++;
      if (d[23:0] !== x.rec) begin
        $error("record_number: expected %0d, got %0d", x.rec, d[23:0]);
        errors++;
      end
      if (d[28:24] !== x.cnt) begin
        $error("crossing_count: expected %0d, got %0d", x.cnt, d[28:24]);
        errors++;
      end
      if (d[32:29] !== x.pos) begin
        $error("position: expected %0d, got %0d", x.pos, d[32:29]);
        errors++;
      end
      if (d[41:33] !== x.val) begin
        $error("entry_value: expected %0d, got %0d", $signed(x.val), $signed(d[41:33]));
        errors++;
      end
      if (l !== x.last) begin
        $error("last_of_record: expected %0d, got %0d", x.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [0:0]          cfg_idx_i = '0;
  logic [RecW-1:0]     cfg_data_i = '0;

  kcrd_entry_book book = new();
  int unsigned    send_idle_pct = 7;
  int unsigned    recv_idle_pct = 50;
  bit             hold_req = 1'b0;
  int unsigned    hold_left = 0;
  logic [7:0]     intro_bytes [11] = '{8'hFF, 8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h12,
                                       8'h34, 8'h56, 8'h7F, 8'h00, 8'h00};

  knot_code_record_decoder_top #(
    .MAX_CROSSINGS(MaxCrossings)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !roll(recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.match_entry(m_axis_tdata, m_axis_tlast);
  end

  task automatic write_reg(logic [0:0] index, logic [RecW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= index;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    book.write_reg(index, value);
  endtask

  task automatic send_byte(logic [7:0] b);
    @(negedge clk_i);
    while (roll(send_idle_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    book.absorb_byte(b);
  endtask

  task automatic send_record();
    int unsigned lastpos, drop, keep, pairs;
    logic [7:0]  h;
    // resync to a header after noise
    while (book.ph != AwaitHeader && !book.halted) send_byte(8'($urandom_range(255, 0)));
    h = 8'($urandom_range(255, 0));
    lastpos = book.nc - 1;
    drop = h / 17;
    keep = (lastpos > drop) ? lastpos - drop : 0;
    pairs = (lastpos - keep + 1) / 2;
    send_byte(h);
    repeat (pairs) send_byte(8'($urandom_range(255, 0)));
    repeat (2) send_byte(8'($urandom_range(255, 0)));
  endtask

  task automatic random_run(int unsigned n);
    int unsigned target;
    target = book.n_bytes + n;
    while (book.n_bytes < target && !book.halted) begin
      if (roll(85)) send_record();
      else repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255, 0)));
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (book.pending_entries.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CfgFirstRecord, 24'd1);
    write_reg(CfgLastRecord, RecMax);

    // record 1 fixes nc = 16; odd count of new entries drops the last low nibble
    foreach (intro_bytes[i]) send_byte(intro_bytes[i]);
    // keep all but the last, keep fourteen, keep thirteen
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h11); send_byte(8'hAB); send_byte(8'hA5); send_byte(8'h5A);
    send_byte(8'h22); send_byte(8'hC3); send_byte(8'h80); send_byte(8'h01);
    random_run(90);
    drain();

    // inverted range: nothing emitted
    write_reg(CfgFirstRecord, RecMax);
    write_reg(CfgLastRecord, RecMax - 1'b1);
    random_run(25);
    drain();

    send_idle_pct = 50;
    recv_idle_pct = 7;
    write_reg(CfgFirstRecord, book.rec_cnt + 24'd4);
    write_reg(CfgLastRecord, RecMax);
    random_run(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgFirstRecord, 24'd1);
    hold_req = 1'b1;
    random_run(60);
    drain();

    // stop after two more records, then feed bytes that must be ignored
    write_reg(CfgLastRecord, book.rec_cnt + 24'd2);
    random_run(1000);
    repeat (10) send_byte(8'($urandom_range(255, 0)));
    drain();

    if (book.pending_entries.size() != 0) begin
      $error("%0d entries never arrived", book.pending_entries.size());
      book.errors++;
    end
    $display("run: %0d stream bytes decoded, %0d records, %0d entries compared",
             book.n_bytes, book.rec_cnt, book.n_entries);
    $display("run: ranges full, inverted, offset and closing stop; block halted = %0d",
             book.halted);
    if (book.errors == 0) begin
      $display("[knot_code_record_decoder_top] OK");
    end else begin
      $display("[knot_code_record_decoder_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[knot_code_record_decoder_top] ERROR");
    $finish;
  end

endmodule
